[hdl/tcw_pkg.sv]
package tcw_pkg;

	// Default screen geometry
	localparam int ROWS_DEF = 25;
	localparam int COLS_DEF = 80;

	// Fixed field widths
	localparam int REQ_W  = 2;
	localparam int CHAR_W = 8;
	localparam int IDX_W  = 11;
	localparam int POS_W  = 11;
	localparam int CELL_W = 16;
	localparam int ATTR_W = 8;

	localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0E;

	// Request codes
	localparam logic [REQ_W-1:0] REQ_PUT   = 2'd0;
	localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd1;
	localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

	// Control characters
	localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;
	localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
	localparam logic [CHAR_W-1:0] CH_RETURN  = 8'd13;

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_PUT    = 7'b0000010,
		S_READ   = 7'b0000100,
		S_RDOUT  = 7'b0001000,
		S_SCROLL = 7'b0010000,
		S_SCTAIL = 7'b0100000,
		S_FILL   = 7'b1000000
	} state_t;

	// What finishes a fill sweep
	typedef enum logic [1:0] {
		FILL_INIT   = 2'd0,
		FILL_CLEAR  = 2'd1,
		FILL_SCROLL = 2'd2
	} fill_mode_t;

endpackage

[hdl/tcw_cell_ram.sv]
module tcw_cell_ram #(
	parameter int DEPTH = tcw_pkg::ROWS_DEF * tcw_pkg::COLS_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [AW-1:0]             waddr,
	input  logic [tcw_pkg::CELL_W-1:0] wdata,
	input  logic [AW-1:0]             raddr,
	output logic [tcw_pkg::CELL_W-1:0] rdata
);

	logic [tcw_pkg::CELL_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

[hdl/text_console_writer.sv]
// Put: S_PUT, then the result strobe; scrolling adds a copy sweep one row up
//   (S_SCROLL, S_SCTAIL) and a bottom-row zero fill. Read: S_READ, S_RDOUT.
// Clear: a full-screen fill. One word at a time; busy stays high until the
//   result strobe cycle. The single cell RAM port pair sets the sweep lengths.
// Reset (arst_n low) homes the cursor, loads attribute 0x0E, then a zeroing
//   sweep of every cell runs with busy high. Results cannot be stalled.
module text_console_writer #(
	parameter int SCREEN_ROWS = tcw_pkg::ROWS_DEF,
	parameter int SCREEN_COLS = tcw_pkg::COLS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [tcw_pkg::REQ_W-1:0]   req_type,
	input  logic [tcw_pkg::CHAR_W-1:0]  char_code,
	input  logic [tcw_pkg::IDX_W-1:0]   cell_index,
	input  logic                        cfg_we,
	input  logic [tcw_pkg::ATTR_W-1:0]  cfg_data,
	output logic                        done,
	output logic [tcw_pkg::POS_W-1:0]   cursor_pos,
	output logic [tcw_pkg::CELL_W-1:0]  cell_data
);

	localparam int NUM_CELLS = SCREEN_ROWS * SCREEN_COLS;
	localparam int AW = $clog2(NUM_CELLS);
	localparam int RW = $clog2(SCREEN_ROWS);
	localparam int CW = $clog2(SCREEN_COLS);
	// compare width for the read index range check
	localparam int XW = (AW + 1 > tcw_pkg::IDX_W) ? AW + 1 : tcw_pkg::IDX_W;
	// width holding both a cell address and a cursor position
	localparam int PW = (AW > tcw_pkg::POS_W) ? AW : tcw_pkg::POS_W;

	localparam logic [AW-1:0] LAST_CELL  = AW'(NUM_CELLS - 1);
	localparam logic [AW-1:0] BOTTOM_ROW = AW'(NUM_CELLS - SCREEN_COLS);
	localparam logic [AW-1:0] COLS_A     = AW'(SCREEN_COLS);
	localparam logic [RW-1:0] LAST_ROW   = RW'(SCREEN_ROWS - 1);
	localparam logic [CW-1:0] LAST_COL   = CW'(SCREEN_COLS - 1);
	localparam logic [XW-1:0] NUM_X      = XW'(NUM_CELLS);

	tcw_pkg::state_t     state_q;
	tcw_pkg::fill_mode_t mode_q;

	logic [RW-1:0]                   row_q;
	logic [CW-1:0]                   col_q;
	logic [AW-1:0]                   lin_q;     // row_q * SCREEN_COLS + col_q
	logic [tcw_pkg::POS_W-1:0]       cursor_q;
	logic [tcw_pkg::ATTR_W-1:0]      attr_q;
	logic [AW-1:0]                   wr_ptr_q;
	logic [AW-1:0]                   rd_ptr_q;
	logic                            pend_s1;   // read data of the scroll copy is due
	logic                            done_q;

	logic [tcw_pkg::CHAR_W-1:0]      char_q;
	logic [AW-1:0]                   idx_q;
	logic                            idx_ok_q;
	logic [tcw_pkg::CELL_W-1:0]      cell_data_q;

	logic [XW-1:0]                   idx_x;
	logic                            accept;

	// Shared address adder
	logic [AW-1:0] add_a;
	logic [AW-1:0] add_b;
	logic [AW-1:0] sum;

	// Put decode
	logic          is_sp;
	logic          is_nl;
	logic          is_cr;
	logic          adv_row;
	logic          need_scroll;
	logic          wr_cell;
	logic [RW-1:0] row_next;
	logic [CW-1:0] col_next;

	// Cell RAM port
	logic                        ram_we;
	logic [AW-1:0]               ram_waddr;
	logic [tcw_pkg::CELL_W-1:0]  ram_wdata;
	logic [AW-1:0]               ram_raddr;
	logic [tcw_pkg::CELL_W-1:0]  ram_rdata;

	function automatic logic [tcw_pkg::POS_W-1:0] pos_of(input logic [AW-1:0] lin);
		logic [PW-1:0] ext;
		ext = PW'(lin);
		return ext[tcw_pkg::POS_W-1:0];
	endfunction

	assign accept = start && (state_q == tcw_pkg::S_IDLE);
	assign idx_x  = XW'(cell_index);

	// Decode the held character
	always_comb begin
		is_sp   = (char_q == tcw_pkg::CH_SPACE);
		is_nl   = (char_q == tcw_pkg::CH_NEWLINE);
		is_cr   = (char_q == tcw_pkg::CH_RETURN);
		wr_cell = !is_sp && !is_nl && !is_cr;
		// newline always moves down; space and printables only on column wrap
		adv_row = is_nl || (!is_cr && (col_q == LAST_COL));
		need_scroll = adv_row && (row_q == LAST_ROW);
		row_next = adv_row ? row_q + RW'(1) : row_q;
		col_next = (is_nl || is_cr || (col_q == LAST_COL)) ? '0 : col_q + CW'(1);
	end

	// One adder: cursor arithmetic during a put, sweep pointer step otherwise
	always_comb begin
		if (state_q == tcw_pkg::S_PUT) begin
			add_a = lin_q;
			if (is_nl) begin
				add_b = COLS_A - AW'(col_q);    // back to column 0, one row down
			end else if (is_cr) begin
				add_b = AW'(0) - AW'(col_q);    // back to column 0
			end else begin
				add_b = AW'(1);
			end
		end else begin
			add_a = wr_ptr_q;
			add_b = AW'(1);
		end
		sum = add_a + add_b;
	end

	// Cell RAM write and read selection
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = wr_ptr_q;
		ram_wdata = ram_rdata;
		unique case (state_q)
			tcw_pkg::S_PUT: begin
				ram_we    = wr_cell;
				ram_waddr = lin_q;
				ram_wdata = {attr_q, char_q};
			end
			tcw_pkg::S_FILL: begin
				ram_we    = 1'b1;
				ram_wdata = (mode_q == tcw_pkg::FILL_CLEAR) ?
					{attr_q, tcw_pkg::CHAR_W'(0)} : '0;
			end
			tcw_pkg::S_SCROLL, tcw_pkg::S_SCTAIL: begin
				// copy the word read in the previous cycle one row up
				ram_we = pend_s1;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
		ram_raddr = (state_q == tcw_pkg::S_SCROLL) ? rd_ptr_q : idx_q;
	end

	tcw_cell_ram #(
		.DEPTH (NUM_CELLS),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= tcw_pkg::S_FILL;    // zero the cell store after reset
			mode_q   <= tcw_pkg::FILL_INIT;
			row_q    <= '0;
			col_q    <= '0;
			lin_q    <= '0;
			cursor_q <= '0;
			attr_q   <= tcw_pkg::ATTR_RESET;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			pend_s1  <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			done_q  <= 1'b0;
			pend_s1 <= 1'b0;
			if (cfg_we) begin
				attr_q <= cfg_data;
			end
			unique case (state_q)
				tcw_pkg::S_IDLE: begin
					if (start) begin
						unique case (req_type)
							tcw_pkg::REQ_PUT: begin
								state_q <= tcw_pkg::S_PUT;
							end
							tcw_pkg::REQ_CLEAR: begin
								wr_ptr_q <= '0;
								mode_q   <= tcw_pkg::FILL_CLEAR;
								state_q  <= tcw_pkg::S_FILL;
							end
							tcw_pkg::REQ_READ: begin
								state_q <= tcw_pkg::S_READ;
							end
							default: begin
								// unused code: report the cursor, change nothing
								done_q <= 1'b1;
							end
						endcase
					end
				end
				tcw_pkg::S_PUT: begin
					if (need_scroll) begin
						rd_ptr_q <= COLS_A;
						wr_ptr_q <= '0;
						mode_q   <= tcw_pkg::FILL_SCROLL;
						state_q  <= tcw_pkg::S_SCROLL;
					end else begin
						row_q    <= row_next;
						col_q    <= col_next;
						lin_q    <= sum;
						cursor_q <= pos_of(sum);
						done_q   <= 1'b1;
						state_q  <= tcw_pkg::S_IDLE;
					end
				end
				tcw_pkg::S_READ: begin
					state_q <= tcw_pkg::S_RDOUT;
				end
				tcw_pkg::S_RDOUT: begin
					done_q  <= 1'b1;
					state_q <= tcw_pkg::S_IDLE;
				end
				tcw_pkg::S_SCROLL: begin
					pend_s1  <= 1'b1;
					rd_ptr_q <= rd_ptr_q + AW'(1);
					if (pend_s1) begin
						wr_ptr_q <= sum;
					end
					if (rd_ptr_q == LAST_CELL) begin
						state_q <= tcw_pkg::S_SCTAIL;
					end
				end
				tcw_pkg::S_SCTAIL: begin
					// last copy lands; pointer now sits on the bottom row
					wr_ptr_q <= sum;
					state_q  <= tcw_pkg::S_FILL;
				end
				tcw_pkg::S_FILL: begin
					wr_ptr_q <= sum;
					if (wr_ptr_q == LAST_CELL) begin
						state_q <= tcw_pkg::S_IDLE;
						case (mode_q)
							tcw_pkg::FILL_CLEAR: begin
								row_q  <= '0;
								col_q  <= '0;
								lin_q  <= '0;
								done_q <= 1'b1;
							end
							tcw_pkg::FILL_SCROLL: begin
								row_q    <= LAST_ROW;
								col_q    <= '0;
								lin_q    <= BOTTOM_ROW;
								cursor_q <= pos_of(BOTTOM_ROW);
								done_q   <= 1'b1;
							end
							default: begin
								done_q <= 1'b0;
							end
						endcase
					end
				end
				default: begin
					state_q <= tcw_pkg::S_IDLE;
				end
			endcase
		end
	end

	// Request payload and read result
	always_ff @(posedge clk) begin
		if (accept) begin
			char_q   <= char_code;
			idx_q    <= idx_x[AW-1:0];
			idx_ok_q <= (idx_x < NUM_X);
		end
		// zero for every result but a read of a cell in range
		cell_data_q <= ((state_q == tcw_pkg::S_RDOUT) && idx_ok_q) ? ram_rdata : '0;
	end

	assign busy       = (state_q != tcw_pkg::S_IDLE);
	assign done       = done_q;
	assign cursor_pos = cursor_q;
	assign cell_data  = cell_data_q;

	// Checks
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("state register not one-hot");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy)
		else $error("result strobe while busy");

	a_cursor_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(cursor_q) |-> done_q)
		else $error("cursor register moved without a result");

	a_lin_track: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tcw_pkg::S_IDLE) |->
			(int'(lin_q) == int'(row_q) * SCREEN_COLS + int'(col_q)))
		else $error("linear cursor out of step with row and column");

	a_scroll_order: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == tcw_pkg::S_SCROLL) && pend_s1) |-> (wr_ptr_q < rd_ptr_q))
		else $error("scroll copy overtook its source");

endmodule
